[design/dlsc_pkg.sv]
package dlsc_pkg;

  // element format codes
  localparam logic [2:0] FMT_FP64 = 3'd0;
  localparam logic [2:0] FMT_FP32 = 3'd1;
  localparam logic [2:0] FMT_FP16 = 3'd2;
  localparam logic [2:0] FMT_BF16 = 3'd3;

  // configuration register indexes
  localparam logic [2:0] REG_START_SCALE = 3'd0;
  localparam logic [2:0] REG_BACKOFF     = 3'd1;
  localparam logic [2:0] REG_GROWTH      = 3'd2;
  localparam logic [2:0] REG_INTERVAL    = 3'd3;
  localparam logic [2:0] REG_FORMAT      = 3'd4;

  // reset values
  localparam logic [31:0] RST_SCALE    = 32'h4780_0000;
  localparam logic [7:0]  RST_BACKOFF  = 8'd2;
  localparam logic [7:0]  RST_GROWTH   = 8'd2;
  localparam logic [15:0] RST_INTERVAL = 16'd2000;
  localparam logic [2:0]  RST_FORMAT   = FMT_FP32;

  // binary32 constants and fp64 limit
  localparam logic [31:0] FP_ONE   = 32'h3F80_0000;
  localparam logic [31:0] FP_QUIET = 32'h0040_0000;
  localparam logic [62:0] FP64_NARROW_LIMIT = 63'h47EF_FFFF_F000_0000;

  // quotient bits produced by the divider
  localparam logic [5:0] DIV_STEPS = 6'd33;

  // update settings seen by the back end
  typedef struct packed {
    logic [7:0]  backoff;
    logic [7:0]  growth;
    logic [15:0] interval;
  } upd_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_NORM,
    ST_ROUND,
    ST_OUT
  } back_state_t;

endpackage

[design/dlsc_front.sv]
module dlsc_front (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [2:0]  fmt,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        in_tuser,
  input  logic        in_tlast,
  input  logic        q_full,
  output logic        q_push,
  output logic        q_wdata
);

  logic seen_r, seen_nxt;
  logic bad;
  logic accept;

  // overflow check per format
  always_comb begin
    case (fmt)
      dlsc_pkg::FMT_FP64: bad = (in_tdata[62:0] >= dlsc_pkg::FP64_NARROW_LIMIT);
      dlsc_pkg::FMT_FP32: bad = (in_tdata[30:23] == 8'hFF);
      dlsc_pkg::FMT_FP16: bad = (in_tdata[14:10] == 5'h1F);
      dlsc_pkg::FMT_BF16: bad = (in_tdata[14:7] == 8'hFF);
      default:            bad = 1'b0;
    endcase
  end

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign q_push    = accept && in_tlast;
  assign q_wdata   = seen_r || (bad && !in_tuser);

  // sticky step flag
  always_comb begin
    seen_nxt = seen_r;
    if (accept) begin
      seen_nxt = in_tlast ? 1'b0 : q_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

endmodule

[design/dlsc_queue.sv]
module dlsc_queue (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  logic wdata,
  input  logic pop,
  output logic full,
  output logic valid,
  output logic rdata
);

  logic [1:0] slot_r, slot_nxt;
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign rdata = slot_r[rptr_r];

  // two-entry ring
  always_comb begin
    slot_nxt = slot_r;
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      slot_nxt[wptr_r] = wdata;
      wptr_nxt = !wptr_r;
    end
    if (pop) begin
      rptr_nxt = !rptr_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

[design/dlsc_back.sv]
module dlsc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  dlsc_pkg::upd_cfg_t cfg,
  input  logic               scale_load,
  input  logic [31:0]        scale_load_val,
  input  logic               q_valid,
  input  logic               q_rdata,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [55:0]        out_tdata
);

  dlsc_pkg::back_state_t state_r, state_nxt;

  logic [31:0] scale_r, scale_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        ovf_r, ovf_nxt;
  logic        sign_r, sign_nxt;
  logic        is_div_r, is_div_nxt;
  logic [33:0] n_r, n_nxt;
  logic [9:0]  x_r, x_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [32:0] dvd_r, dvd_nxt;
  logic [5:0]  iter_r, iter_nxt;

  logic [7:0]  s_exp;
  logic [22:0] s_frac;
  logic        s_nan, s_inf, s_zero;
  logic [7:0]  dv, gv;
  logic [15:0] cnt1;
  logic        grow, need_div, need_mul;
  logic [8:0]  rem_sh;
  logic        ge;
  logic [31:0] prod;
  logic [23:0] mant;
  logic        rbit, sticky, up;
  logic [24:0] msum;
  logic [9:0]  field;
  logic [31:0] rnd_val;

  // scale decode
  assign s_exp  = scale_r[30:23];
  assign s_frac = scale_r[22:0];
  assign s_nan  = (s_exp == 8'hFF) && (s_frac != 23'd0);
  assign s_inf  = (s_exp == 8'hFF) && (s_frac == 23'd0);
  assign s_zero = (s_exp == 8'h00) && (s_frac == 23'd0);

  assign dv   = (cfg.backoff == 8'd0) ? 8'd1 : cfg.backoff;
  assign gv   = (cfg.growth == 8'd0) ? 8'd1 : cfg.growth;
  assign cnt1 = cnt_r + 16'd1;
  assign grow = !q_rdata && (cnt1 >= cfg.interval);

  assign need_div = q_rdata && !scale_r[31] && (s_exp != 8'h00) && (s_exp != 8'hFF);
  assign need_mul = grow && !s_nan && !s_inf && !s_zero;

  // one quotient bit per cycle
  assign rem_sh = {rem_r, dvd_r[32]};
  assign ge     = (rem_sh >= {1'b0, dv});

  assign prod = {8'd0, (s_exp != 8'h00), s_frac} * {24'd0, gv};

  // round to nearest even from the normalized word; backoff results below one become one
  always_comb begin
    mant   = n_r[33:10];
    rbit   = n_r[9];
    sticky = (n_r[8:0] != 9'd0) || (rem_r != 8'd0);
    up     = rbit && (sticky || mant[0]);
    msum   = {1'b0, mant} + {24'd0, up};
    if (msum[24]) begin
      field = x_r + 10'd1;
    end else if (msum[23]) begin
      field = x_r;
    end else begin
      field = 10'd0;
    end
    if (field >= 10'd255) begin
      rnd_val = {sign_r, 8'hFF, 23'd0};
    end else begin
      rnd_val = {sign_r, field[7:0], msum[24] ? 23'd0 : msum[22:0]};
    end
    if (is_div_r && (field < 10'd127)) begin
      rnd_val = dlsc_pkg::FP_ONE;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dlsc_pkg::ST_IDLE: begin
        if (q_valid) begin
          if (!s_nan && need_div) begin
            state_nxt = dlsc_pkg::ST_DIV;
          end else if (!s_nan && need_mul) begin
            state_nxt = dlsc_pkg::ST_NORM;
          end else begin
            state_nxt = dlsc_pkg::ST_OUT;
          end
        end
      end
      dlsc_pkg::ST_DIV: begin
        if (iter_r == 6'd1) begin
          state_nxt = dlsc_pkg::ST_NORM;
        end
      end
      dlsc_pkg::ST_NORM: begin
        if (n_r[33] || (x_r <= 10'd1)) begin
          state_nxt = dlsc_pkg::ST_ROUND;
        end
      end
      dlsc_pkg::ST_ROUND: state_nxt = dlsc_pkg::ST_OUT;
      dlsc_pkg::ST_OUT: begin
        if (out_tready) begin
          state_nxt = dlsc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dlsc_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    q_pop      = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      dlsc_pkg::ST_IDLE: q_pop = q_valid;
      dlsc_pkg::ST_OUT:  out_tvalid = 1'b1;
      default: begin
        q_pop      = 1'b0;
        out_tvalid = 1'b0;
      end
    endcase
  end

  assign out_tdata = {7'd0, cnt_r, scale_r, ovf_r};

  // datapath
  always_comb begin
    scale_nxt  = scale_r;
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    sign_nxt   = sign_r;
    is_div_nxt = is_div_r;
    n_nxt      = n_r;
    x_nxt      = x_r;
    rem_nxt    = rem_r;
    dvd_nxt    = dvd_r;
    iter_nxt   = iter_r;
    case (state_r)
      dlsc_pkg::ST_IDLE: begin
        if (scale_load) begin
          scale_nxt = scale_load_val;
        end
        if (q_valid) begin
          ovf_nxt = q_rdata;
          cnt_nxt = (q_rdata || grow) ? 16'd0 : cnt1;
          if (s_nan) begin
            scale_nxt = scale_r | dlsc_pkg::FP_QUIET;
          end else if (q_rdata) begin
            if (need_div) begin
              dvd_nxt    = {1'b1, s_frac, 9'd0};
              rem_nxt    = 8'd0;
              iter_nxt   = dlsc_pkg::DIV_STEPS;
              n_nxt      = 34'd0;
              x_nxt      = {2'd0, s_exp} + 10'd1;
              sign_nxt   = 1'b0;
              is_div_nxt = 1'b1;
            end else if (!(s_inf && !scale_r[31])) begin
              scale_nxt = dlsc_pkg::FP_ONE;
            end
          end else if (need_mul) begin
            n_nxt      = {prod, 2'b00};
            x_nxt      = ((s_exp == 8'h00) ? 10'd1 : {2'd0, s_exp}) + 10'd8;
            rem_nxt    = 8'd0;
            sign_nxt   = scale_r[31];
            is_div_nxt = 1'b0;
          end
        end
      end
      dlsc_pkg::ST_DIV: begin
        rem_nxt  = ge ? 8'(rem_sh - {1'b0, dv}) : rem_sh[7:0];
        n_nxt    = {n_r[32:0], ge};
        dvd_nxt  = {dvd_r[31:0], 1'b0};
        iter_nxt = iter_r - 6'd1;
      end
      dlsc_pkg::ST_NORM: begin
        if (!n_r[33] && (x_r > 10'd1)) begin
          n_nxt = {n_r[32:0], 1'b0};
          x_nxt = x_r - 10'd1;
        end
      end
      dlsc_pkg::ST_ROUND: scale_nxt = rnd_val;
      default: scale_nxt = scale_r;
    endcase
  end

  always_ff @(posedge clk) begin
    sign_r   <= sign_nxt;
    is_div_r <= is_div_nxt;
    n_r      <= n_nxt;
    x_r      <= x_nxt;
    rem_r    <= rem_nxt;
    dvd_r    <= dvd_nxt;
    iter_r   <= iter_nxt;
    if (!rst_n) begin
      state_r <= dlsc_pkg::ST_IDLE;
      scale_r <= dlsc_pkg::RST_SCALE;
      cnt_r   <= 16'd0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      scale_r <= scale_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

[design/dynamic_loss_scale_controller.sv]
// channel  direction  contents
// in_      slave      tdata: grad_word[63:0]; tuser: skip_element; tlast: last_of_step
// out_     master     tdata: step_overflow, scale_bits, clean_steps (low bit up)
// cfg_     write      cfg_addr selects start scale, backoff, growth, interval, format
//
// elements are taken one per cycle while the queue is not full; a step end hands
// a word to a two-entry queue and the back end updates the scale from it
// an update with no arithmetic goes straight to output; growth runs the normalize
// loop and rounding, and backoff runs the bit-serial divider before them
// reset loads the register defaults; the scan stalls only when the queue is full
module dynamic_loss_scale_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // grad_word
  input  logic        in_tuser,   // skip_element
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // step_overflow, scale_bits[32:1], clean_steps[48:33]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  logic [7:0]  backoff_r;
  logic [7:0]  growth_r;
  logic [15:0] interval_r;
  logic [2:0]  format_r;
  dlsc_pkg::upd_cfg_t cfg;
  logic q_full, q_push, q_wdata, q_pop, q_valid, q_rdata;
  logic scale_load;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backoff_r  <= dlsc_pkg::RST_BACKOFF;
      growth_r   <= dlsc_pkg::RST_GROWTH;
      interval_r <= dlsc_pkg::RST_INTERVAL;
      format_r   <= dlsc_pkg::RST_FORMAT;
    end else if (cfg_we) begin
      case (cfg_addr)
        dlsc_pkg::REG_BACKOFF:  backoff_r  <= cfg_wdata[7:0];
        dlsc_pkg::REG_GROWTH:   growth_r   <= cfg_wdata[7:0];
        dlsc_pkg::REG_INTERVAL: interval_r <= cfg_wdata[15:0];
        dlsc_pkg::REG_FORMAT:   format_r   <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  assign scale_load   = cfg_we && (cfg_addr == dlsc_pkg::REG_START_SCALE);
  assign cfg.backoff  = backoff_r;
  assign cfg.growth   = growth_r;
  assign cfg.interval = interval_r;

  dlsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .fmt       (format_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  dlsc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .full  (q_full),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  dlsc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .scale_load     (scale_load),
    .scale_load_val (cfg_wdata),
    .q_valid        (q_valid),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata)
  );

endmodule

[verif/dlsc_scale_checker.sv]
module dlsc_scale_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,   // grad_word
  input  logic        in_tuser,   // skip_element
  input  logic        in_tlast,   // last_of_step
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,  // step_overflow, scale_bits, clean_steps
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          steps_pending,
  output int          steps_checked,
  output int          overflow_steps
);

  typedef struct packed {
    logic        ovf;
    logic [31:0] scale;
    logic [15:0] clean;
  } step_result_t;

  step_result_t expected_steps[$];

  // shadow registers and state
  logic [7:0]  backoff_r;
  logic [7:0]  growth_r;
  logic [15:0] interval_r;
  logic [2:0]  format_r;
  logic [31:0] scale_r;
  logic [15:0] count_r;
  logic        ovf_r;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch step %0d: %s got %h want %h", steps_checked, what, got, want);
    fail_count++;
  endtask

  // overflow test of one element for the current format
  function automatic logic element_overflows(logic [63:0] w);
    case (format_r)
      dlsc_pkg::FMT_FP64: return w[62:0] >= dlsc_pkg::FP64_NARROW_LIMIT;
      dlsc_pkg::FMT_FP32: return w[30:23] == 8'hff;
      dlsc_pkg::FMT_FP16: return w[14:10] == 5'h1f;
      dlsc_pkg::FMT_BF16: return w[14:7] == 8'hff;
      default:            return 1'b0;
    endcase
  endfunction

  // round mag * 2^e2 to binary32, nearest even, with sticky from below
  function automatic logic [31:0] round_f32(logic sgn, logic [63:0] mag, int e2, logic sticky_in);
    int p;
    int sh;
    int ex;
    logic [63:0] k;
    logic guard;
    logic stk;
    if (mag == 0) return {sgn, 31'd0};
    p = 63;
    while (!mag[p]) p--;
    sh = p - 23;
    if (-149 - e2 > sh) sh = -149 - e2;
    if (sh > 0) begin
      k = mag >> sh;
      guard = mag[sh-1];
      stk = sticky_in || ((mag & ((64'd1 << (sh - 1)) - 1)) != 0);
      if (guard && (stk || k[0])) k++;
    end else begin
      k = mag << (-sh);
    end
    if (k[24]) begin
      k = k >> 1;
      sh++;
    end
    if (!k[23]) return {sgn, 8'd0, k[22:0]};
    ex = e2 + sh + 150;
    if (ex >= 255) return {sgn, 8'hff, 23'd0};
    return {sgn, ex[7:0], k[22:0]};
  endfunction

  function automatic logic [31:0] scale_backoff(logic [31:0] s, logic [7:0] d);
    logic [63:0] m;
    logic [63:0] num;
    logic [31:0] r;
    int e2;
    if (d == 0) d = 8'd1;
    if (s[30:23] == 8'hff) return s[31] ? dlsc_pkg::FP_ONE : s;
    m  = (s[30:23] == 0) ? {41'd0, s[22:0]} : {40'd0, 1'b1, s[22:0]};
    e2 = (s[30:23] == 0) ? -149 : int'(s[30:23]) - 150;
    num = m << 40;
    r = round_f32(1'b0, num / d, e2 - 40, (num % d) != 0);
    // floor at one, which also catches negative scales
    if (s[31] || r < dlsc_pkg::FP_ONE) r = dlsc_pkg::FP_ONE;
    return r;
  endfunction

  function automatic logic [31:0] scale_grow(logic [31:0] s, logic [7:0] g);
    logic [63:0] m;
    int e2;
    if (g == 0) g = 8'd1;
    if (s[30:23] == 8'hff) return s;
    m  = (s[30:23] == 0) ? {41'd0, s[22:0]} : {40'd0, 1'b1, s[22:0]};
    e2 = (s[30:23] == 0) ? -149 : int'(s[30:23]) - 150;
    return round_f32(s[31], m * g, e2, 1'b0);
  endfunction

  // step end: new scale and count
  task automatic close_step();
    step_result_t r;
    logic nan_scale;
    nan_scale = (scale_r[30:23] == 8'hff) && (scale_r[22:0] != 0);
    if (ovf_r) begin
      count_r = 16'd0;
      scale_r = nan_scale ? (scale_r | dlsc_pkg::FP_QUIET) : scale_backoff(scale_r, backoff_r);
      overflow_steps++;
    end else begin
      count_r = count_r + 16'd1;
      if (nan_scale) scale_r = scale_r | dlsc_pkg::FP_QUIET;
      if (count_r >= interval_r) begin
        if (!nan_scale) scale_r = scale_grow(scale_r, growth_r);
        count_r = 16'd0;
      end
    end
    r.ovf = ovf_r;
    r.scale = scale_r;
    r.clean = count_r;
    expected_steps.push_back(r);
    ovf_r = 1'b0;
  endtask

  always @(posedge clk) begin
    step_result_t want;
    if (!rst_n) begin
      backoff_r  = dlsc_pkg::RST_BACKOFF;
      growth_r   = dlsc_pkg::RST_GROWTH;
      interval_r = dlsc_pkg::RST_INTERVAL;
      format_r   = dlsc_pkg::RST_FORMAT;
      scale_r    = dlsc_pkg::RST_SCALE;
      count_r    = 16'd0;
      ovf_r      = 1'b0;
      fail_count     = 0;
      steps_checked  = 0;
      overflow_steps = 0;
      expected_steps.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_addr)
          dlsc_pkg::REG_START_SCALE: scale_r = cfg_wdata;
          dlsc_pkg::REG_BACKOFF:     backoff_r = cfg_wdata[7:0];
          dlsc_pkg::REG_GROWTH:      growth_r = cfg_wdata[7:0];
          dlsc_pkg::REG_INTERVAL:    interval_r = cfg_wdata[15:0];
          dlsc_pkg::REG_FORMAT:      format_r = cfg_wdata[2:0];
          default: ;
        endcase
      end
      // accepted element
      if (in_tvalid && in_tready) begin
        if (!in_tuser && element_overflows(in_tdata)) ovf_r = 1'b1;
        if (in_tlast) close_step();
      end
      // accepted result word
      if (out_tvalid && out_tready) begin
        if (expected_steps.size() == 0) begin
          report("unexpected word", out_tdata[32:1], 32'd0);
        end else begin
          want = expected_steps.pop_front();
          if (out_tdata[0] !== want.ovf)
            report("step_overflow", {31'd0, out_tdata[0]}, {31'd0, want.ovf});
          if (out_tdata[32:1] !== want.scale)
            report("scale_bits", out_tdata[32:1], want.scale);
          if (out_tdata[48:33] !== want.clean)
            report("clean_steps", {16'd0, out_tdata[48:33]}, {16'd0, want.clean});
          if (out_tdata[55:49] !== 7'd0)
            report("pad bits", {25'd0, out_tdata[55:49]}, 32'd0);
        end
        steps_checked++;
      end
    end
    steps_pending = expected_steps.size();
  end

endmodule

[verif/tb_dynamic_loss_scale_controller.sv]
module tb_dynamic_loss_scale_controller;

  localparam logic [2:0] FMT_INT = 3'd4;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // grad_word
  logic        in_tuser;   // skip_element
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // step_overflow, scale_bits, clean_steps
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [31:0] cfg_wdata;

  int fail_count;
  int steps_pending;
  int steps_checked;
  int overflow_steps;
  int words_sent;
  int idle_cycles;
  bit no_idle;
  int out_stall_left;
  logic [2:0] cur_format;

  dynamic_loss_scale_controller DUT (.*);

  dlsc_scale_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall_left = 0;
    end else if (out_stall_left > 0) begin
      out_tready <= 1'b0;
      out_stall_left--;
    end else if (no_idle || $urandom_range(99) < 80) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
      out_stall_left = ($urandom_range(9) == 0) ? $urandom_range(40, 15) : $urandom_range(3);
    end
  end

  // watchdog on lack of progress
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no progress for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    if (idx == dlsc_pkg::REG_FORMAT) cur_format = val[2:0];
    @(posedge clk);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // let every step result come back and the back end go quiet
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (steps_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one gradient word, with an optional random gap in front
  task automatic send_word(input logic [63:0] w, input logic skip, input logic last);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(99) < 30)
      gap = ($urandom_range(15) == 0) ? $urandom_range(30, 10) : $urandom_range(3, 1);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    in_tuser  <= skip;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  // random element, clean unless forced bad, for the current format
  function automatic logic [63:0] rand_grad(input logic bad);
    logic [63:0] w;
    w = {$urandom, $urandom};
    case (cur_format)
      dlsc_pkg::FMT_FP64:
        if (bad) w[62:52] = 11'h7ff;
        else if (w[62:0] >= dlsc_pkg::FP64_NARROW_LIMIT) w[62] = 1'b0;
      dlsc_pkg::FMT_FP32: if (bad) w[30:23] = 8'hff; else w[30] = w[30] & ~(&w[29:23]);
      dlsc_pkg::FMT_FP16: if (bad) w[14:10] = 5'h1f; else w[14] = w[14] & ~(&w[13:10]);
      dlsc_pkg::FMT_BF16: if (bad) w[14:7] = 8'hff; else w[14] = w[14] & ~(&w[13:7]);
      default: ;
    endcase
    return w;
  endfunction

  task automatic random_steps(input int n_words);
    int left;
    int len;
    int i;
    logic bad_step;
    left = n_words;
    while (left > 0) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(20, 9) : $urandom_range(6, 1);
      bad_step = ($urandom_range(99) < 30);
      for (i = 0; i < len; i++)
        send_word(rand_grad(bad_step && $urandom_range(len - 1) == 0),
                  ($urandom_range(9) == 0), (i == len - 1));
      left -= len;
    end
  endtask

  initial begin
    logic [31:0] scales[7];
    int phase;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= 64'd0;
    in_tuser   <= 1'b0;
    in_tlast   <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_addr   <= dlsc_pkg::REG_START_SCALE;
    cfg_wdata  <= 32'd0;
    cur_format = dlsc_pkg::RST_FORMAT;
    words_sent = 0;
    no_idle    = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults: fp32 infinity, NaN, largest finite, skipped bad last word
    send_word(64'h0000_0000_7f80_0000, 1'b0, 1'b1);
    send_word(64'hffff_ffff_7f7f_ffff, 1'b0, 1'b0);
    send_word(64'h0000_0000_ffc0_0001, 1'b0, 1'b1);
    send_word(64'h0000_0000_7f80_0000, 1'b1, 1'b1);
    drain();

    // fp64 narrowing threshold, with fast growth
    write_reg(dlsc_pkg::REG_FORMAT, {29'd0, dlsc_pkg::FMT_FP64});
    write_reg(dlsc_pkg::REG_INTERVAL, 32'd1);
    write_reg(dlsc_pkg::REG_GROWTH, 32'd255);
    write_reg(dlsc_pkg::REG_BACKOFF, 32'd255);
    end_writes();
    send_word({1'b0, dlsc_pkg::FP64_NARROW_LIMIT - 63'd1}, 1'b0, 1'b1);
    send_word({1'b1, dlsc_pkg::FP64_NARROW_LIMIT}, 1'b0, 1'b1);
    send_word(64'h7ff0_0000_0000_0000, 1'b0, 1'b1);
    drain();

    // half and bfloat, upper bits set but ignored
    write_reg(dlsc_pkg::REG_FORMAT, {29'd0, dlsc_pkg::FMT_FP16});
    write_reg(dlsc_pkg::REG_INTERVAL, 32'd0);
    write_reg(dlsc_pkg::REG_GROWTH, 32'd0);
    write_reg(dlsc_pkg::REG_BACKOFF, 32'd0);
    end_writes();
    send_word(64'hffff_ffff_ffff_bbff, 1'b0, 1'b1);
    send_word(64'h0000_0000_0000_fc00, 1'b0, 1'b1);
    drain();
    write_reg(dlsc_pkg::REG_FORMAT, {29'd0, dlsc_pkg::FMT_BF16});
    write_reg(dlsc_pkg::REG_INTERVAL, 32'd65535);
    write_reg(dlsc_pkg::REG_BACKOFF, 32'd1);
    end_writes();
    send_word(64'hffff_ffff_ffff_bf7f, 1'b0, 1'b1);
    send_word(64'h0000_0000_0000_7f81, 1'b0, 1'b1);
    drain();

    // integer and spare codes never flag; NaN, negative and tiny scales
    write_reg(dlsc_pkg::REG_FORMAT, {29'd0, FMT_INT});
    write_reg(dlsc_pkg::REG_START_SCALE, 32'h7f80_0001);
    end_writes();
    send_word(64'hffff_ffff_ffff_ffff, 1'b0, 1'b1);
    drain();
    write_reg(dlsc_pkg::REG_FORMAT, 32'd7);
    write_reg(dlsc_pkg::REG_START_SCALE, 32'hc000_0000);
    write_reg(dlsc_pkg::REG_INTERVAL, 32'd1);
    write_reg(dlsc_pkg::REG_GROWTH, 32'd3);
    end_writes();
    send_word(64'hffff_ffff_ffff_ffff, 1'b0, 1'b1);
    drain();
    write_reg(dlsc_pkg::REG_FORMAT, {29'd0, dlsc_pkg::FMT_FP32});
    write_reg(dlsc_pkg::REG_START_SCALE, 32'h0000_0001);
    write_reg(dlsc_pkg::REG_BACKOFF, 32'd3);
    end_writes();
    send_word(64'd0, 1'b0, 1'b1);
    send_word(64'h0000_0000_ff80_0000, 1'b0, 1'b1);
    drain();

    // random phases over varied settings
    scales = '{32'h7f7f_ffff, 32'h3f80_0000, 32'h0000_0001, 32'hff80_0000,
               32'h4780_0000, 32'h7fff_ffff, 32'h0080_0000};
    for (phase = 0; phase < 12; phase++) begin
      no_idle = (phase % 4 == 3);
      write_reg(dlsc_pkg::REG_START_SCALE, (phase < 7) ? scales[phase] : $urandom);
      write_reg(dlsc_pkg::REG_BACKOFF, (phase == 1) ? 32'd255 : $urandom_range(255));
      write_reg(dlsc_pkg::REG_GROWTH, (phase == 2) ? 32'd255 : $urandom_range(255));
      write_reg(dlsc_pkg::REG_INTERVAL, (phase == 5) ? 32'd65535 : $urandom_range(4));
      write_reg(dlsc_pkg::REG_FORMAT, (phase < 8) ? (phase % 5) : $urandom_range(7));
      end_writes();
      random_steps(80);
      drain();
    end

    $display("sent %0d gradient words in %0d steps, %0d of them overflowing",
             words_sent, steps_checked, overflow_steps);
    $display("covered all five formats, spare codes, NaN/negative/tiny scales, zero factors");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
design/dlsc_pkg.sv
design/dlsc_front.sv
design/dlsc_queue.sv
design/dlsc_back.sv
design/dynamic_loss_scale_controller.sv
verif/dlsc_scale_checker.sv
verif/tb_dynamic_loss_scale_controller.sv
